// ----- hdl/qrad_pkg.sv -----
// Shared types, constants and character lookup for the QR alphanumeric encoder.
`timescale 1ns / 1ps
package qrad_pkg;

   localparam int unsigned RESULT_LIMIT = 64;
   localparam int unsigned RES_CNT_W    = 7;
   localparam int unsigned CSR_W        = 7;
   localparam int unsigned PAIR_W       = 11;
   localparam int unsigned SINGLE_W     = 6;
   localparam int unsigned TERM_BITS    = 4;
   localparam logic [7:0]  PAD_FIRST    = 8'd236;
   localparam logic [7:0]  PAD_SECOND   = 8'd17;
   localparam logic [6:0]  CSR_RESET    = 7'd16;

   typedef enum logic [1:0] {
      ST_DATA    = 2'd0,
      ST_INVALID = 2'd1,
      ST_OVER    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT,
      S_ENDPEND,
      S_TERM,
      S_FILL,
      S_PAD,
      S_REPORT,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] idx;
   } alnum_type;

   typedef struct packed {
      logic push;
      logic bit_val;
      logic pad;
      logic drop;
      logic clear;
   } pk_ctl_type;

   typedef struct packed {
      logic       byte_v;
      logic [7:0] byte_data;
      logic       over;
   } pk_stat_type;

   typedef struct packed {
      logic [7:0] byte_data;
      status_type status;
   } result_type;

   function automatic alnum_type alnum_index(input logic [7:0] code);
      alnum_type r;
      r.ok  = 1'b1;
      r.idx = 6'd0;
      if (code >= 8'h30 && code <= 8'h39) begin
         r.idx = 6'(code - 8'h30);
      end else if (code >= 8'h41 && code <= 8'h5A) begin
         r.idx = 6'(code - 8'h37);
      end else begin
         unique case (code)
            8'h20:   r.idx = 6'd36;
            8'h24:   r.idx = 6'd37;
            8'h25:   r.idx = 6'd38;
            8'h2A:   r.idx = 6'd39;
            8'h2B:   r.idx = 6'd40;
            8'h2D:   r.idx = 6'd41;
            8'h2E:   r.idx = 6'd42;
            8'h2F:   r.idx = 6'd43;
            8'h3A:   r.idx = 6'd44;
            default: r.ok  = 1'b0;
         endcase
      end
      return r;
   endfunction

endpackage

// ----- hdl/qrad_packer.sv -----
// Shared bit packer: collects bits into bytes, emits pad bytes, tracks bytes emitted.
`timescale 1ns / 1ps
module qrad_packer #(
   parameter int unsigned BE_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  qrad_pkg::pk_ctl_type ctl,
   input  logic [BE_W-1:0]      cap,
   output qrad_pkg::pk_stat_type stat,
   output logic [BE_W-1:0]      be,
   output logic [2:0]           pc
);

   logic [6:0]      pb_ff, pb_in;
   logic [2:0]      pc_ff, pc_in;
   logic [BE_W-1:0] be_ff, be_in;
   logic            tog_ff, tog_in;
   logic            full;

   assign full = (be_ff >= cap);
   assign be   = be_ff;
   assign pc   = pc_ff;

   always_comb begin
      pb_in          = pb_ff;
      pc_in          = pc_ff;
      be_in          = be_ff;
      tog_in         = tog_ff;
      stat.byte_v    = 1'b0;
      stat.byte_data = 8'd0;
      stat.over      = 1'b0;
      priority if (ctl.clear) begin
         pb_in  = 7'd0;
         pc_in  = 3'd0;
         be_in  = '0;
         tog_in = 1'b0;
      end else if (ctl.drop) begin
         pb_in = 7'd0;
         pc_in = 3'd0;
      end else if (ctl.pad) begin
         stat.byte_v    = 1'b1;
         stat.byte_data = tog_ff ? qrad_pkg::PAD_SECOND : qrad_pkg::PAD_FIRST;
         tog_in         = ~tog_ff;
         be_in          = be_ff + BE_W'(1);
      end else if (ctl.push) begin
         if (full) begin
            stat.over = 1'b1;
         end else if (pc_ff == 3'd7) begin
            stat.byte_v    = 1'b1;
            stat.byte_data = {pb_ff, ctl.bit_val};
            pb_in          = 7'd0;
            pc_in          = 3'd0;
            be_in          = be_ff + BE_W'(1);
         end else begin
            pb_in = {pb_ff[5:0], ctl.bit_val};
            pc_in = pc_ff + 3'd1;
         end
      end else begin
         pb_in = pb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pb_ff  <= 7'd0;
         pc_ff  <= 3'd0;
         be_ff  <= '0;
         tog_ff <= 1'b0;
      end else begin
         pb_ff  <= pb_in;
         pc_ff  <= pc_in;
         be_ff  <= be_in;
         tog_ff <= tog_in;
      end
   end

endmodule

// ----- hdl/qrad_out_stage.sv -----
// Result holding stage and output register; marks the final item of a message.
`timescale 1ns / 1ps
module qrad_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 gen_v,
   input  qrad_pkg::result_type gen_res,
   input  logic                 flush,
   input  logic                 flush_last,
   output logic                 room,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // out_byte
   output logic [1:0]           rsp_tuser,   // status
   output logic                 rsp_tlast    // last_byte
);

   qrad_pkg::result_type held_ff, held_in;
   logic                 held_v_ff, held_v_in;
   logic                 ov_ff, ov_in;
   logic [7:0]           od_ff, od_in;
   logic [1:0]           ou_ff, ou_in;
   logic                 ol_ff, ol_in;
   logic                 out_free;
   logic                 move;

   assign out_free = ~ov_ff | rsp_tready;
   assign room     = ~held_v_ff | out_free;
   assign move     = (gen_v | flush) & held_v_ff & out_free;

   always_comb begin
      held_in   = held_ff;
      held_v_in = held_v_ff;
      ov_in     = ov_ff & ~rsp_tready;
      od_in     = od_ff;
      ou_in     = ou_ff;
      ol_in     = ol_ff;
      if (move) begin
         ov_in = 1'b1;
         od_in = held_ff.byte_data;
         ou_in = held_ff.status;
         ol_in = flush & flush_last;
      end
      if (gen_v && room) begin
         held_in   = gen_res;
         held_v_in = 1'b1;
      end else if (flush && room) begin
         held_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_v_ff <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         held_v_ff <= held_v_in;
         ov_ff     <= ov_in;
      end
      held_ff <= held_in;
      od_ff   <= od_in;
      ou_ff   <= ou_in;
      ol_ff   <= ol_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ou_ff;
   assign rsp_tlast  = ol_ff;

endmodule

// ----- hdl/qr_alphanumeric_data_encoder.sv -----
// Top level: QR alphanumeric encoder with terminator and pad bytes, bit-serial sequencer.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata[7:0] char_code, tuser has_char,
//                                       tlast end_of_message
//  rsp      out  rsp_tvalid/rsp_tready  tdata[7:0] out_byte, tuser[1:0] status,
//                                       tlast last_byte
//  csr      in   csr_valid/csr_ready    csr_data[6:0] capacity_bytes
//
// One item at a time; req_tready is high only while the sequencer is idle.
// The shared packer takes one bit per cycle while the output stage has room. An
// ending item also shifts out its pending character, terminator and fill bits, then
// pad bytes (up to 63), passing through the terminator, fill and pad phases.
// rsp_tready low holds the sequencer wherever it would produce a result; reset clears state.
`timescale 1ns / 1ps
module qr_alphanumeric_data_encoder #(
   parameter int unsigned MAX_CAPACITY_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // char_code
   input  logic       req_tuser,   // has_char
   input  logic       req_tlast,   // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [1:0] rsp_tuser,   // status
   output logic       rsp_tlast,   // last_byte
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data     // capacity_bytes
);

   localparam int unsigned BE_W = $clog2(MAX_CAPACITY_BYTES + 1);
   localparam logic [6:0]  MAX_CAP = 7'(MAX_CAPACITY_BYTES);

   qrad_pkg::state_type   state_ff, state_in;
   qrad_pkg::alnum_type   idx_ff, idx_in;
   logic                  has_ff, has_in;
   logic                  end_ff, end_in;
   logic [5:0]            pend_ff, pend_in;
   logic                  pend_v_ff, pend_v_in;
   logic [10:0]           shift_ff, shift_in;
   logic [3:0]            scnt_ff, scnt_in;
   logic                  fin_ff, fin_in;
   logic [2:0]            term_ff, term_in;
   logic                  inv_ff, inv_in;
   logic                  over_ff, over_in;
   logic [qrad_pkg::RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic [qrad_pkg::CSR_W-1:0]     csr_ff;

   logic [6:0]            cap_clamp;
   logic [BE_W-1:0]       eff_cap;
   qrad_pkg::pk_ctl_type  pk_ctl;
   qrad_pkg::pk_stat_type pk_stat;
   logic [BE_W-1:0]       pk_be;
   logic [2:0]            pk_pc;
   logic                  room;
   logic                  res_new;
   logic                  gen_v;
   qrad_pkg::result_type  gen_res;
   logic                  flush;
   logic                  has_room_bits;
   logic [10:0]           pair_val;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == qrad_pkg::S_IDLE);

   always_comb begin
      if (csr_ff == 7'd0) begin
         cap_clamp = 7'd1;
      end else if (csr_ff > MAX_CAP) begin
         cap_clamp = MAX_CAP;
      end else begin
         cap_clamp = csr_ff;
      end
   end
   assign eff_cap = cap_clamp[BE_W-1:0];

   assign has_room_bits = ({pk_be, pk_pc} < {eff_cap, 3'b000});
   assign pair_val      = 11'(pend_ff) * 11'd45 + 11'(idx_ff.idx);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      has_in    = has_ff;
      end_in    = end_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      shift_in  = shift_ff;
      scnt_in   = scnt_ff;
      fin_in    = fin_ff;
      term_in   = term_ff;
      inv_in    = inv_ff;
      over_in   = over_ff;
      pk_ctl    = '0;
      res_new   = 1'b0;
      gen_res.byte_data = 8'd0;
      gen_res.status    = qrad_pkg::ST_DATA;
      flush     = 1'b0;
      unique case (state_ff)
         qrad_pkg::S_IDLE: begin
            if (req_tvalid) begin
               idx_in   = qrad_pkg::alnum_index(req_tdata);
               has_in   = req_tuser;
               end_in   = req_tlast;
               fin_in   = 1'b0;
               inv_in   = 1'b0;
               over_in  = 1'b0;
               state_in = qrad_pkg::S_DECODE;
            end
         end
         qrad_pkg::S_DECODE: begin
            state_in = qrad_pkg::S_ENDPEND;
            if (has_ff && !idx_ff.ok) begin
               inv_in = 1'b1;
            end else if (has_ff && pend_v_ff) begin
               shift_in  = pair_val;
               scnt_in   = 4'(qrad_pkg::PAIR_W);
               pend_v_in = 1'b0;
               pend_in   = 6'd0;
               state_in  = qrad_pkg::S_SHIFT;
            end else if (has_ff) begin
               pend_in   = idx_ff.idx;
               pend_v_in = 1'b1;
            end
         end
         qrad_pkg::S_SHIFT: begin
            if (room) begin
               pk_ctl.push    = 1'b1;
               pk_ctl.bit_val = shift_ff[10];
               shift_in       = {shift_ff[9:0], 1'b0};
               scnt_in        = scnt_ff - 4'd1;
               if (scnt_ff == 4'd1) begin
                  state_in = fin_ff ? qrad_pkg::S_TERM : qrad_pkg::S_ENDPEND;
               end
            end
         end
         qrad_pkg::S_ENDPEND: begin
            term_in = 3'd0;
            if (!end_ff) begin
               state_in = qrad_pkg::S_REPORT;
            end else if (pend_v_ff) begin
               shift_in  = {pend_ff, 5'b00000};
               scnt_in   = 4'(qrad_pkg::SINGLE_W);
               pend_v_in = 1'b0;
               pend_in   = 6'd0;
               fin_in    = 1'b1;
               state_in  = qrad_pkg::S_SHIFT;
            end else begin
               state_in = qrad_pkg::S_TERM;
            end
         end
         qrad_pkg::S_TERM: begin
            if (term_ff != 3'(qrad_pkg::TERM_BITS) && has_room_bits) begin
               if (room) begin
                  pk_ctl.push = 1'b1;
                  term_in     = term_ff + 3'd1;
               end
            end else begin
               state_in = qrad_pkg::S_FILL;
            end
         end
         qrad_pkg::S_FILL: begin
            if (pk_pc == 3'd0) begin
               state_in = qrad_pkg::S_PAD;
            end else if (pk_be >= eff_cap) begin
               pk_ctl.drop = 1'b1;
               over_in     = 1'b1;
               state_in    = qrad_pkg::S_PAD;
            end else if (room) begin
               pk_ctl.push = 1'b1;
            end
         end
         qrad_pkg::S_PAD: begin
            if (pk_be >= eff_cap) begin
               state_in = qrad_pkg::S_REPORT;
            end else if (room) begin
               pk_ctl.pad = 1'b1;
            end
         end
         qrad_pkg::S_REPORT: begin
            if (inv_ff) begin
               if (room) begin
                  res_new        = 1'b1;
                  gen_res.status = qrad_pkg::ST_INVALID;
                  inv_in         = 1'b0;
               end
            end else if (over_ff) begin
               if (room) begin
                  res_new        = 1'b1;
                  gen_res.status = qrad_pkg::ST_OVER;
                  over_in        = 1'b0;
               end
            end else begin
               state_in = qrad_pkg::S_FLUSH;
            end
         end
         qrad_pkg::S_FLUSH: begin
            flush = 1'b1;
            if (room) begin
               state_in = qrad_pkg::S_IDLE;
               if (end_ff) begin
                  pk_ctl.clear = 1'b1;
                  pend_v_in    = 1'b0;
                  pend_in      = 6'd0;
               end
            end
         end
         default: state_in = qrad_pkg::S_IDLE;
      endcase
      if (pk_stat.over) begin
         over_in = 1'b1;
      end
      if (pk_stat.byte_v) begin
         res_new           = 1'b1;
         gen_res.byte_data = pk_stat.byte_data;
         gen_res.status    = qrad_pkg::ST_DATA;
      end
   end

   assign gen_v = res_new && (res_cnt_ff < qrad_pkg::RES_CNT_W'(qrad_pkg::RESULT_LIMIT));

   always_comb begin
      res_cnt_in = res_cnt_ff;
      if (state_ff == qrad_pkg::S_IDLE && req_tvalid) begin
         res_cnt_in = '0;
      end else if (gen_v) begin
         res_cnt_in = res_cnt_ff + qrad_pkg::RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= qrad_pkg::S_IDLE;
         pend_v_ff  <= 1'b0;
         pend_ff    <= 6'd0;
         fin_ff     <= 1'b0;
         inv_ff     <= 1'b0;
         over_ff    <= 1'b0;
         res_cnt_ff <= '0;
         term_ff    <= 3'd0;
         csr_ff     <= qrad_pkg::CSR_RESET;
      end else begin
         state_ff   <= state_in;
         pend_v_ff  <= pend_v_in;
         pend_ff    <= pend_in;
         fin_ff     <= fin_in;
         inv_ff     <= inv_in;
         over_ff    <= over_in;
         res_cnt_ff <= res_cnt_in;
         term_ff    <= term_in;
         if (csr_valid && csr_ready) begin
            csr_ff <= csr_data;
         end
      end
      idx_ff   <= idx_in;
      has_ff   <= has_in;
      end_ff   <= end_in;
      shift_ff <= shift_in;
      scnt_ff  <= scnt_in;
   end

   qrad_packer #(
      .BE_W (BE_W)
   ) u_packer (
      .clock (clock),
      .reset (reset),
      .ctl   (pk_ctl),
      .cap   (eff_cap),
      .stat  (pk_stat),
      .be    (pk_be),
      .pc    (pk_pc)
   );

   qrad_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .gen_v      (gen_v),
      .gen_res    (gen_res),
      .flush      (flush),
      .flush_last (end_ff),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == qrad_pkg::S_IDLE && $past(state_ff) == qrad_pkg::S_FLUSH && $past(end_ff))
      |-> (pk_be == '0 && pk_pc == 3'd0 && !pend_v_ff))
      else $error("encoder state not cleared after message end");

   a_pad_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == qrad_pkg::S_PAD) |-> (pk_pc == 3'd0))
      else $error("pad bytes started off a byte boundary");

   a_res_limit: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= qrad_pkg::RES_CNT_W'(qrad_pkg::RESULT_LIMIT))
      else $error("result count past limit");

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == qrad_pkg::S_IDLE) |-> (!pk_ctl.push && !pk_ctl.pad && !gen_v))
      else $error("packer active while idle");

endmodule

// ----- bench/qrad_encode_check.sv -----
// Watches the req, rsp and csr channels, predicts the encoded byte stream and compares it.
`timescale 1ns / 1ps
module qrad_encode_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [1:0] rsp_tuser,
   input  logic       rsp_tlast,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [6:0] csr_data,
   output int         fail_count,
   output int         due_count,
   output int         bytes_seen
);

   localparam logic [45*8-1:0] ALNUM_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
   localparam int unsigned CAP_MAX = 64;

   typedef struct packed {
      logic [7:0]           code;
      qrad_pkg::status_type status;
      logic                 last;
   } coded_item_type;

   logic [6:0]  cap_reg;
   logic [5:0]  held_idx;
   logic        held_valid;
   logic [6:0]  acc_bits;
   logic [2:0]  acc_cnt;
   logic [6:0]  bytes_out;
   logic        overflowed;
   coded_item_type step_out[$];
   coded_item_type coded_due[$];

   function automatic int alnum_pos(input logic [7:0] ch);
      for (int i = 0; i < 45; i++) begin
         if (ALNUM_SET[(44 - i) * 8 +: 8] == ch) return i;
      end
      return -1;
   endfunction

   function automatic int unsigned cap_limit();
      if (cap_reg == 7'd0) return 1;
      if (cap_reg > 7'(CAP_MAX)) return CAP_MAX;
      return int'(cap_reg);
   endfunction

   task automatic clear_state();
      held_idx   = '0;
      held_valid = 1'b0;
      acc_bits   = '0;
      acc_cnt    = '0;
      bytes_out  = '0;
   endtask

   task automatic emit(input logic [7:0] value, input qrad_pkg::status_type st);
      coded_item_type r;
      if (step_out.size() < qrad_pkg::RESULT_LIMIT) begin
         r.code   = value;
         r.status = st;
         r.last   = 1'b0;
         step_out.push_back(r);
      end
   endtask

   task automatic shift_in(input logic b);
      if (int'(bytes_out) >= cap_limit()) begin
         overflowed = 1'b1;
      end else if (acc_cnt == 3'd7) begin
         emit({acc_bits, b}, qrad_pkg::ST_DATA);
         acc_bits = '0;
         acc_cnt  = '0;
         bytes_out++;
      end else begin
         acc_bits = {acc_bits[5:0], b};
         acc_cnt++;
      end
   endtask

   task automatic shift_value(input logic [10:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) shift_in(v[i]);
   endtask

   // pending single, terminator, zero fill to a byte boundary, then alternating pad bytes
   task automatic close_message();
      int unsigned cap;
      int unsigned used;
      int unsigned room;
      logic        pad_alt;
      cap     = cap_limit();
      pad_alt = 1'b0;
      if (held_valid) begin
         shift_value(11'(held_idx), qrad_pkg::SINGLE_W);
         held_valid = 1'b0;
         held_idx   = '0;
      end
      used = int'(bytes_out) * 8 + int'(acc_cnt);
      room = (cap * 8 > used) ? cap * 8 - used : 0;
      for (int unsigned t = 0; t < qrad_pkg::TERM_BITS && t < room; t++) shift_in(1'b0);
      if (acc_cnt != 3'd0) begin
         if (int'(bytes_out) >= cap) begin
            overflowed = 1'b1;
            acc_bits   = '0;
            acc_cnt    = '0;
         end else begin
            while (acc_cnt != 3'd0) shift_in(1'b0);
         end
      end
      while (int'(bytes_out) < cap) begin
         emit(pad_alt ? qrad_pkg::PAD_SECOND : qrad_pkg::PAD_FIRST, qrad_pkg::ST_DATA);
         pad_alt = ~pad_alt;
         bytes_out++;
      end
   endtask

   task automatic encode_item(input logic [7:0] ch, input logic has, input logic fin);
      int             pos;
      logic           bad;
      coded_item_type tail;
      step_out.delete();
      overflowed = 1'b0;
      bad        = 1'b0;
      if (has) begin
         pos = alnum_pos(ch);
         if (pos < 0) begin
            bad = 1'b1;
         end else if (held_valid) begin
            shift_value(11'(int'(held_idx) * 45 + pos), qrad_pkg::PAIR_W);
            held_valid = 1'b0;
            held_idx   = '0;
         end else begin
            held_idx   = 6'(pos);
            held_valid = 1'b1;
         end
      end
      if (fin) close_message();
      if (bad) emit(8'd0, qrad_pkg::ST_INVALID);
      if (overflowed) emit(8'd0, qrad_pkg::ST_OVER);
      if (fin) begin
         if (step_out.size() > 0) begin
            tail      = step_out.pop_back();
            tail.last = 1'b1;
            step_out.push_back(tail);
         end
         clear_state();
      end
      foreach (step_out[i]) coded_due.push_back(step_out[i]);
   endtask

   task automatic check_result();
      coded_item_type want;
      bytes_seen++;
      if (coded_due.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: unexpected rsp item byte %0d status %0d last %0d",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
      end else begin
         want = coded_due.pop_front();
         if (want.code !== rsp_tdata || want.status !== rsp_tuser || want.last !== rsp_tlast) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: rsp item expected byte %0d status %0d last %0d, got %0d %0d %0d",
                        $time, want.code, want.status, want.last,
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cap_reg    = qrad_pkg::CSR_RESET;
         fail_count = 0;
         bytes_seen = 0;
         clear_state();
         coded_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_valid && csr_ready) cap_reg = csr_data;
         if (req_tvalid && req_tready) encode_item(req_tdata, req_tuser, req_tlast);
      end
      due_count = coded_due.size();
   end

endmodule

// ----- bench/testbench.sv -----
// Top of the bench: clock, reset, stimulus for the QR alphanumeric encoder and the verdict.
`timescale 1ns / 1ps
module testbench;

   localparam logic [45*8-1:0] ALNUM_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
   localparam int SETTLE_CYCLES = 150;
   localparam int RANDOM_ITEMS  = 100;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;
   logic       req_tuser  = 1'b0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data   = qrad_pkg::CSR_RESET;

   int fail_count;
   int due_count;
   int bytes_seen;
   int items_sent = 0;
   int cap_writes = 0;
   int sink_wait  = 0;
   bit calm       = 1'b0;

   qr_alphanumeric_data_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   qrad_encode_check u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .due_count  (due_count),
      .bytes_seen (bytes_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_wait();
      if (calm) return 0;
      return $urandom_range(0, 17);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         sink_wait = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sink_wait = draw_wait();
         if (sink_wait > 0) begin
            sink_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [7:0] ch, input logic has, input logic fin);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= has;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // only between items, once every expected item is out and the block has settled
   task automatic write_capacity(input logic [6:0] value);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (due_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cap_writes++;
   endtask

   // mostly valid characters, some invalid codes and empty items
   task automatic send_message(input int len);
      logic [7:0] ch;
      logic       has;
      logic       joined;
      int         pick;
      joined = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 19);
         has  = (pick != 1);
         if (pick <= 1) ch = 8'($urandom_range(0, 255));
         else ch = ALNUM_SET[(44 - $urandom_range(0, 44)) * 8 +: 8];
         send_item(ch, has, joined && i == len - 1);
      end
      if (!joined || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      int         base;
      int         sel;
      logic [6:0] cap;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_item("0", 1'b1, 1'b0);
      send_item("0", 1'b1, 1'b0);
      send_item(":", 1'b1, 1'b0);
      send_item(":", 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item("Z", 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(":", 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item("A", 1'b1, 1'b1);
      send_item(8'h80, 1'b1, 1'b1);
      // one byte of room: the pair overflows, then the end item yields nothing
      write_capacity(7'd1);
      send_item("A", 1'b1, 1'b0);
      send_item("B", 1'b1, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);
      send_item("7", 1'b1, 1'b1);
      write_capacity(7'd0);
      send_item("C", 1'b1, 1'b1);
      // a zero byte and 63 pad bytes fill the step, the invalid report falls off
      write_capacity(7'd64);
      send_item(8'h7F, 1'b1, 1'b1);
      write_capacity(7'd127);
      send_item("H", 1'b1, 1'b0);
      send_item("I", 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      // capacity dropped below what the open message already holds
      write_capacity(7'd16);
      send_item("A", 1'b1, 1'b0);
      send_item("B", 1'b1, 1'b0);
      write_capacity(7'd1);
      send_item(8'h00, 1'b0, 1'b1);

      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0:       cap = 7'd0;
            1:       cap = 7'd127;
            2:       cap = 7'd64;
            3:       cap = 7'd1;
            default: cap = 7'($urandom_range(1, 20));
         endcase
         write_capacity(cap);
         calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 4)) send_message($urandom_range(0, 9));
      end

      req_tvalid <= 1'b0;
      do @(negedge clock); while (due_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("covered %0d req items, %0d rsp items checked, %0d capacity writes",
               items_sent, bytes_seen, cap_writes);
      if (fail_count == 0 && due_count == 0) begin
         $display("qr_alphanumeric_data_encoder: match");
      end else begin
         $display("qr_alphanumeric_data_encoder: mismatch");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("qr_alphanumeric_data_encoder: mismatch");
      $finish;
   end

endmodule
